// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/cpd_pkg.sv =====
// Types, character codes and digit decoding for the packet deframer.
`timescale 1ns / 1ps
package cpd_pkg;

   localparam logic [7:0] StartMark = 8'h24;
   localparam logic [7:0] EndMark   = 8'h23;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharLowA  = 8'h61;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } in_beat_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       packet_end;
      logic       checksum_ok;
   } result_type;

   function automatic logic [7:0] decode_digit(input logic [7:0] c);
      logic [7:0] val;
      if (c > CharNine) begin
         val = c - CharLowA + 8'd10;
      end else begin
         val = c - CharZero;
      end
      return val;
   endfunction

endpackage

// ===== hw/rtl/checksummed_packet_deframer_top.sv =====
// Top level of the checksummed packet deframer.
//   channel | direction | beat contents
//   req_    | in        | rx_byte[7:0]
//   rsp_    | out       | payload_byte[7:0], packet_end, checksum_ok
// One byte per cycle sustained while rsp_ready stays high; each byte is registered in the
// input register, and its result, if any, in the result register around the parser.
// Reset (synchronous, active high) empties both registers and returns to hunting for '$'.
// A stalled rsp_ holds the result register; the input register then fills and
// req_ready drops until the result beat is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module checksummed_packet_deframer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_packet_end,
   output logic       rsp_checksum_ok
);

   cpd_pkg::in_beat_type beat;
   cpd_pkg::result_type  res;
   logic                 res_valid;
   logic                 advance;

   cpd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .beat        (beat)
   );

   cpd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res)
   );

   cpd_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .res_valid        (res_valid),
      .res              (res),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_checksum_ok  (rsp_checksum_ok)
   );

   `ASSERT_IMPLIES(a_stall, clock, reset, !req_ready, beat.valid && rsp_valid && !rsp_ready)
   `ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && req_ready, beat.valid)
   `ASSERT_IMPLIES(a_end_zero, clock, reset, rsp_valid && rsp_packet_end, rsp_payload_byte == 8'd0)
   `ASSERT_IMPLIES(a_data_no_ok, clock, reset, rsp_valid && !rsp_packet_end, !rsp_checksum_ok)

endmodule

// ===== hw/rtl/cpd_in_reg.sv =====
// Input register stage: holds one received beat until the parser advances.
`timescale 1ns / 1ps
module cpd_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 advance,
   output cpd_pkg::in_beat_type beat
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
      if (req_ready && req_valid) begin
         byte_in = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign beat.valid   = valid_ff;
   assign beat.rx_byte = byte_ff;

endmodule

// ===== hw/rtl/cpd_parse.sv =====
// Framing state machine: hunts for start, sums payload, checks the hex checksum.
`timescale 1ns / 1ps
module cpd_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  cpd_pkg::in_beat_type beat,
   input  logic                 advance,
   output logic                 res_valid,
   output cpd_pkg::result_type  res
);

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_DATA   = 2'd1,
      PH_CHK_HI = 2'd2,
      PH_CHK_LO = 2'd3
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] high_ff, high_in;
   logic [7:0] digit;
   logic [7:0] expected;
   logic       step;

   assign step     = beat.valid && advance;
   assign digit    = cpd_pkg::decode_digit(beat.rx_byte);
   assign expected = {high_ff[3:0], 4'b0000} | digit;

   always_comb begin
      phase_in         = phase_ff;
      sum_in           = sum_ff;
      high_in          = high_ff;
      res_valid        = 1'b0;
      res.payload_byte = 8'd0;
      res.packet_end   = 1'b0;
      res.checksum_ok  = 1'b0;
      case (phase_ff)
         PH_HUNT: begin
            if (beat.rx_byte == cpd_pkg::StartMark) begin
               sum_in   = 8'd0;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (beat.rx_byte == cpd_pkg::EndMark) begin
               phase_in = PH_CHK_HI;
            end else begin
               sum_in           = sum_ff + beat.rx_byte;
               res_valid        = beat.valid;
               res.payload_byte = beat.rx_byte;
            end
         end
         PH_CHK_HI: begin
            high_in  = digit;
            phase_in = PH_CHK_LO;
         end
         PH_CHK_LO: begin
            res_valid       = beat.valid;
            res.packet_end  = 1'b1;
            res.checksum_ok = (expected == sum_ff);
            phase_in        = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         sum_ff   <= 8'd0;
         high_ff  <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         high_ff  <= high_in;
      end
   end

endmodule

// ===== hw/rtl/cpd_out_reg.sv =====
// Result register: holds one result beat until the consumer takes it.
`timescale 1ns / 1ps
module cpd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   input  cpd_pkg::result_type res,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_payload_byte,
   output logic                rsp_packet_end,
   output logic                rsp_checksum_ok
);

   logic                valid_ff, valid_in;
   cpd_pkg::result_type data_ff, data_in;

   assign advance = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = res_valid;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_payload_byte = data_ff.payload_byte;
   assign rsp_packet_end   = data_ff.packet_end;
   assign rsp_checksum_ok  = data_ff.checksum_ok;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the checksummed packet deframer top level.
`timescale 1ns / 1ps
module tb_top;

   typedef cpd_pkg::result_type result_type;

   typedef enum logic [1:0] {Hunt, Payload, SumHigh, SumLow} parse_phase_type;

   typedef struct {
      logic [7:0] rx;
      bit         typed;
      bit         yields;
      result_type res;
   } directed_row_type;

   localparam int StallLimit   = 2000;
   localparam int FramedTarget = 1700;
   localparam int TailCycles   = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_packet_end;
   logic       rsp_checksum_ok;

   checksummed_packet_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_checksum_ok  (rsp_checksum_ok)
   );

   parse_phase_type parse_phase = Hunt;
   logic [7:0]      payload_sum = 8'h00;
   logic [7:0]      high_digit = 8'h00;

   result_type       pending_results[$];
   directed_row_type directed[$];

   bit            cur_typed = 1'b0;
   bit            cur_yields = 1'b0;
   result_type    cur_res = '0;

   int            idle_pct = 0;
   int            stall_pct = 0;
   int            errors = 0;
   int            quiet_cycles = 0;
   int            accepted_beats = 0;
   int            framed_beats = 0;
   int            payload_results = 0;
   int            packets_closed = 0;
   int            bad_sums = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [7:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c > cpd_pkg::CharNine) begin
         v = c - cpd_pkg::CharLowA + 8'd10;
      end else begin
         v = c - cpd_pkg::CharZero;
      end
      return v;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = cpd_pkg::CharZero + {4'h0, nib};
      end else begin
         ch = cpd_pkg::CharLowA + {4'h0, nib} - 8'd10;
      end
      return ch;
   endfunction

   function automatic bit deframe_byte(input logic [7:0] c, output result_type r);
      bit         produced;
      logic [7:0] received_sum;
      produced = 1'b0;
      r = '0;
      case (parse_phase)
         Hunt: begin
            if (c == cpd_pkg::StartMark) begin
               payload_sum = 8'h00;
               parse_phase = Payload;
            end
         end
         Payload: begin
            if (c == cpd_pkg::EndMark) begin
               parse_phase = SumHigh;
            end else begin
               payload_sum = payload_sum + c;
               r.payload_byte = c;
               produced = 1'b1;
            end
         end
         SumHigh: begin
            high_digit = hex_value(c);
            parse_phase = SumLow;
         end
         default: begin
            received_sum = {high_digit[3:0], 4'h0} | hex_value(c);
            r.packet_end = 1'b1;
            r.checksum_ok = (received_sum == payload_sum);
            produced = 1'b1;
            parse_phase = Hunt;
         end
      endcase
      return produced;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic add_row(input logic [7:0] rx, input bit typed, input bit yields,
                          input result_type res);
      directed.insert(directed.size(), '{rx, typed, yields, res});
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type predicted;
      bit         yields;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_packet_end) begin
               packets_closed++;
               if (!rsp_checksum_ok) bad_sums++;
            end else begin
               payload_results++;
            end
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat byte=%h end=%b ok=%b",
                  rsp_payload_byte, rsp_packet_end, rsp_checksum_ok));
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload_byte !== want.payload_byte)
                  report_mismatch($sformatf("payload_byte got %h want %h",
                     rsp_payload_byte, want.payload_byte));
               if (rsp_packet_end !== want.packet_end)
                  report_mismatch($sformatf("packet_end got %b want %b",
                     rsp_packet_end, want.packet_end));
               if (rsp_checksum_ok !== want.checksum_ok)
                  report_mismatch($sformatf("checksum_ok got %b want %b",
                     rsp_checksum_ok, want.checksum_ok));
            end
         end
         if (req_valid && req_ready) begin
            accepted_beats++;
            yields = deframe_byte(req_rx_byte, predicted);
            if (cur_typed) begin
               yields = cur_yields;
               predicted = cur_res;
            end
            if (yields) pending_results.insert(pending_results.size(), predicted);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
               $display("timeout: no beat moved for %0d cycles", StallLimit);
               $display("checksummed_packet_deframer_top test failed");
               $finish;
            end
         end
      end
   end

   task automatic send_beat(input logic [7:0] b, input bit typed, input bit yields,
                            input result_type res);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      cur_typed = typed;
      cur_yields = yields;
      cur_res = res;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_plain(input logic [7:0] b);
      send_beat(b, 1'b0, 1'b0, '0);
   endtask

   task automatic send_random_packet();
      int         len;
      int         kind;
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] hi;
      logic [7:0] lo;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(4, 1)) send_plain(8'($urandom_range(255)));
      end
      send_plain(cpd_pkg::StartMark);
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
      sum = 8'h00;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(255));
         sum = sum + b;
         send_plain(b);
      end
      framed_beats += len + 1;
      kind = $urandom_range(99);
      if (kind < 5) return;
      hi = hex_char(sum[7:4]);
      lo = hex_char(sum[3:0]);
      if (kind < 70) begin
      end else if (kind < 80) begin
         if (hi > cpd_pkg::CharNine) hi = hi - 8'h20;
         if (lo > cpd_pkg::CharNine) lo = lo - 8'h20;
      end else if (kind < 90) begin
         if ($urandom_range(1)) hi = hex_char(4'($urandom_range(15)));
         else lo = hex_char(4'($urandom_range(15)));
      end else begin
         hi = 8'($urandom_range(255));
         lo = 8'($urandom_range(255));
      end
      send_plain(cpd_pkg::EndMark);
      send_plain(hi);
      send_plain(lo);
      framed_beats += 3;
   endtask

   initial begin
      add_row(8'h00, 1'b1, 1'b0, result_type'('0));
      add_row(8'hFF, 1'b1, 1'b0, result_type'('0));
      add_row(cpd_pkg::StartMark, 1'b1, 1'b0, result_type'('0));
      add_row(8'hFF, 1'b1, 1'b1, result_type'{8'hFF, 1'b0, 1'b0});
      add_row(8'h00, 1'b1, 1'b1, result_type'{8'h00, 1'b0, 1'b0});
      add_row(cpd_pkg::StartMark, 1'b1, 1'b1, result_type'{cpd_pkg::StartMark, 1'b0, 1'b0});
      add_row(cpd_pkg::EndMark, 1'b1, 1'b0, result_type'('0));
      add_row(8'h32, 1'b1, 1'b0, result_type'('0));
      add_row(8'h33, 1'b1, 1'b1, result_type'{8'h00, 1'b1, 1'b1});
      add_row(cpd_pkg::StartMark, 1'b0, 1'b0, result_type'('0));
      add_row(8'h41, 1'b0, 1'b0, result_type'('0));
      add_row(cpd_pkg::EndMark, 1'b0, 1'b0, result_type'('0));
      add_row(8'h41, 1'b0, 1'b0, result_type'('0));
      add_row(8'h31, 1'b0, 1'b0, result_type'('0));
      add_row(cpd_pkg::StartMark, 1'b0, 1'b0, result_type'('0));
      add_row(8'h9A, 1'b1, 1'b1, result_type'{8'h9A, 1'b0, 1'b0});
      add_row(cpd_pkg::EndMark, 1'b1, 1'b0, result_type'('0));
      add_row(8'h39, 1'b1, 1'b0, result_type'('0));
      add_row(8'h61, 1'b1, 1'b1, result_type'{8'h00, 1'b1, 1'b1});
      add_row(cpd_pkg::StartMark, 1'b0, 1'b0, result_type'('0));
      add_row(cpd_pkg::EndMark, 1'b0, 1'b0, result_type'('0));
      add_row(cpd_pkg::StartMark, 1'b0, 1'b0, result_type'('0));
      add_row(cpd_pkg::EndMark, 1'b0, 1'b0, result_type'('0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_beat(directed[i].rx, directed[i].typed, directed[i].yields, directed[i].res);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         while (framed_beats < (ph + 1) * FramedTarget / 4) send_random_packet();
         // hold the sender until every pending result has drained
         req_valid <= 1'b0;
         while (pending_results.size() != 0) @(posedge clock);
         @(negedge clock);
      end

      repeat (TailCycles) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      $display("covered %0d input beats, %0d payload results, %0d packets (%0d bad sums)",
         accepted_beats, payload_results, packets_closed, bad_sums);
      $display("idle mixes: none, sender 54%%, receiver 54%%, both 26%%; %0d errors", errors);
      if (errors == 0) begin
         $display("checksummed_packet_deframer_top test passed");
      end else begin
         $display("checksummed_packet_deframer_top test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cpd_pkg.sv
hw/rtl/cpd_in_reg.sv
hw/rtl/cpd_parse.sv
hw/rtl/cpd_out_reg.sv
hw/rtl/checksummed_packet_deframer_top.sv
sim/tb_top.sv
